// ===== src/qvr_pkg.sv =====
// Package: payload types, widths and shared constants for the quaternion rotate core.
`default_nettype none
package qvr_pkg;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               zero_vector;
  } qvr_out_t;

  // sum of squares, <= 3*2^30
  localparam int SumW   = 32;
  // radicand s*2^32 and its root (length with 16 fraction bits)
  localparam int RadW   = 64;
  localparam int LenW   = 32;
  // root bits resolved per stage
  localparam int SqrtPerStg = 2;
  localparam int SqrtStg    = LenW / SqrtPerStg;
  // dividend |v|*2^30 + L/2 < 2^46; quotient <= 2^14
  localparam int DvdW   = 47;
  localparam int QuoW   = 15;
  localparam int DivPerStg = 2;
  localparam int DivStg    = (QuoW + DivPerStg - 1) / DivPerStg;

endpackage
`default_nettype wire

// ===== src/qvr_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
`default_nettype none
module qvr_isqrt
  import qvr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire logic [SumW-1:0] in_sum,
  input  wire qvr_in_t         in_req,
  output logic                 out_vld,
  output logic [LenW-1:0]      out_len,
  output qvr_in_t              out_req,
  output logic                 out_zero
);

  // rem/root state per stage; root built MSB first (restoring method on s*2^32)
  logic [SqrtStg:1]     vld_r;
  logic [RadW-1:0]      rad_r  [1:SqrtStg];
  logic [LenW+1:0]      rem_r  [1:SqrtStg];
  logic [LenW-1:0]      root_r [1:SqrtStg];
  qvr_in_t              req_r  [1:SqrtStg];
  logic [SqrtStg:1]     zero_r;

  for (genvar g = 0; g < SqrtStg; g++) begin : g_stg
    logic            vld_cur;
    logic            zero_cur;
    logic [RadW-1:0] rad_cur;
    logic [LenW+1:0] rem_cur;
    logic [LenW-1:0] root_cur;
    qvr_in_t         req_cur;
    logic [RadW-1:0] rad_nxt;
    logic [LenW+1:0] rem_nxt;
    logic [LenW-1:0] root_nxt;

    // first stage starts from the raw sum, later ones from the previous stage
    if (g == 0) begin : g_head
      assign vld_cur  = in_vld;
      assign rad_cur  = {in_sum, 32'd0};
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign req_cur  = in_req;
      assign zero_cur = (in_sum == '0);
    end else begin : g_body
      assign vld_cur  = vld_r[g];
      assign rad_cur  = rad_r[g];
      assign rem_cur  = rem_r[g];
      assign root_cur = root_r[g];
      assign req_cur  = req_r[g];
      assign zero_cur = zero_r[g];
    end

    always_comb begin
      logic [LenW+1:0] rm;
      logic [LenW-1:0] rt;
      logic [RadW-1:0] rd;
      logic [LenW+1:0] trial;
      rm = rem_cur;
      rt = root_cur;
      rd = rad_cur;
      for (int k = 0; k < SqrtPerStg; k++) begin
        rm    = {rm[LenW-1:0], rd[RadW-1 -: 2]};
        rd    = {rd[RadW-3:0], 2'b00};
        trial = {rt, 2'b01};
        if (rm >= trial) begin
          rm = rm - trial;
          rt = {rt[LenW-2:0], 1'b1};
        end else begin
          rt = {rt[LenW-2:0], 1'b0};
        end
      end
      rad_nxt  = rd;
      rem_nxt  = rm;
      root_nxt = rt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_cur;
      end
      rad_r[g+1]  <= rad_nxt;
      rem_r[g+1]  <= rem_nxt;
      root_r[g+1] <= root_nxt;
      req_r[g+1]  <= req_cur;
      zero_r[g+1] <= zero_cur;
    end
  end

  assign out_vld  = vld_r[SqrtStg];
  assign out_len  = root_r[SqrtStg];
  assign out_req  = req_r[SqrtStg];
  assign out_zero = zero_r[SqrtStg];

endmodule
`default_nettype wire

// ===== src/qvr_udiv.sv =====
// Pipelined unsigned divider for one normalized vector component, two quotient bits per stage.
`default_nettype none
module qvr_udiv
  import qvr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [DvdW-1:0] in_dvd,
  input  wire logic [LenW-1:0] in_dsr,
  output logic [QuoW-1:0]      out_quo
);

  localparam int Bits = DivStg * DivPerStg;

  // remainder stays below divisor, so LenW+1 bits suffice
  logic [LenW:0]      rem_r [1:DivStg];
  logic [Bits-1:0]    quo_r [1:DivStg];
  logic [DvdW-1:0]    dvd_r [1:DivStg];
  logic [LenW-1:0]    dsr_r [1:DivStg];

  for (genvar g = 0; g < DivStg; g++) begin : g_stg
    logic [LenW:0]    rem_cur;
    logic [Bits-1:0]  quo_cur;
    logic [DvdW-1:0]  dvd_cur;
    logic [LenW-1:0]  dsr_cur;
    logic [LenW:0]    rem_nxt;
    logic [Bits-1:0]  quo_nxt;
    logic [DvdW-1:0]  dvd_nxt;

    // quotient < 2^15, so the top DvdW-Bits dividend bits already sit below the divisor
    if (g == 0) begin : g_head
      assign rem_cur = (LenW+1)'(in_dvd[DvdW-1:Bits]);
      assign quo_cur = '0;
      assign dvd_cur = in_dvd << (DvdW - Bits);
      assign dsr_cur = in_dsr;
    end else begin : g_body
      assign rem_cur = rem_r[g];
      assign quo_cur = quo_r[g];
      assign dvd_cur = dvd_r[g];
      assign dsr_cur = dsr_r[g];
    end

    always_comb begin
      logic [LenW+1:0]  rm;
      logic [Bits-1:0]  qu;
      logic [DvdW-1:0]  dv;
      rm = {1'b0, rem_cur};
      qu = quo_cur;
      dv = dvd_cur;
      for (int k = 0; k < DivPerStg; k++) begin
        rm = {rm[LenW:0], dv[DvdW-1]};
        dv = {dv[DvdW-2:0], 1'b0};
        if (rm >= {2'b00, dsr_cur}) begin
          rm = rm - {2'b00, dsr_cur};
          qu = {qu[Bits-2:0], 1'b1};
        end else begin
          qu = {qu[Bits-2:0], 1'b0};
        end
      end
      rem_nxt = rm[LenW:0];
      quo_nxt = qu;
      dvd_nxt = dv;
    end
    always_ff @(posedge clk) begin
      rem_r[g+1] <= rem_nxt;
      quo_r[g+1] <= quo_nxt;
      dvd_r[g+1] <= dvd_nxt;
      dsr_r[g+1] <= dsr_cur;
    end
  end

  assign out_quo = quo_r[DivStg][QuoW-1:0];

endmodule
`default_nettype wire

// ===== src/quaternion_vector_rotate_core.sv =====
// Top level: normalize a vector and rotate it by a quaternion, fully pipelined.
//
// One request is taken every clock cycle; busy is tied low, so start alone
// launches a request. Each request yields one result, shown on out_data for a
// single cycle with out_strobe high. The request passes 31 register stages
// (1 squaring stage, 16 square-root stages, 8 divider stages, 1 sign stage,
// 2 stages for the inner Hamilton product, 2 for the outer one, 1 for
// rounding), the first loaded at the start edge. The square-root pipeline,
// two root bits per stage, makes up the bulk of those stages. Results come
// in request order and the receiver cannot stall them. A zero vector gives
// zero outputs and raises zero_vector.
`default_nettype none
module quaternion_vector_rotate_core
  import qvr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire qvr_in_t  in_data,
  output logic          out_strobe,
  output qvr_out_t      out_data
);

  assign busy = 1'b0;

  // stage 1: squares summed
  logic     s1_vld_r;
  logic [SumW-1:0] s1_sum_r;
  qvr_in_t  s1_req_r;
  logic [SumW-1:0] sum_nxt;

  always_comb begin
    logic signed [31:0] px, py, pz;
    px = in_data.vec_x * in_data.vec_x;
    py = in_data.vec_y * in_data.vec_y;
    pz = in_data.vec_z * in_data.vec_z;
    sum_nxt = SumW'(unsigned'(px)) + SumW'(unsigned'(py)) + SumW'(unsigned'(pz));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_sum_r <= sum_nxt;
    s1_req_r <= in_data;
  end

  // square root
  logic            sq_vld;
  logic [LenW-1:0] sq_len;
  qvr_in_t         sq_req;
  logic            sq_zero;

  qvr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld_r),
    .in_sum   (s1_sum_r),
    .in_req   (s1_req_r),
    .out_vld  (sq_vld),
    .out_len  (sq_len),
    .out_req  (sq_req),
    .out_zero (sq_zero)
  );

  // dividers: |v|*2^30 + L/2 over L, one per component; length forced
  // nonzero for zero vectors (result discarded anyway)
  logic [LenW-1:0] dsr;
  logic [DvdW-1:0] dvd_x, dvd_y, dvd_z;
  logic [QuoW-1:0] quo_x, quo_y, quo_z;

  function automatic logic [DvdW-1:0] mk_dvd(logic signed [15:0] v, logic [LenW-1:0] l);
    logic [15:0] mag;
    mag = v[15] ? 16'(-v) : v;
    return {1'b0, mag, 30'd0} + DvdW'(l >> 1);
  endfunction

  assign dsr   = sq_zero ? LenW'(1) : sq_len;
  assign dvd_x = mk_dvd(sq_req.vec_x, sq_len);
  assign dvd_y = mk_dvd(sq_req.vec_y, sq_len);
  assign dvd_z = mk_dvd(sq_req.vec_z, sq_len);

  qvr_udiv u_div_x (.clk(clk), .in_dvd(dvd_x), .in_dsr(dsr), .out_quo(quo_x));
  qvr_udiv u_div_y (.clk(clk), .in_dvd(dvd_y), .in_dsr(dsr), .out_quo(quo_y));
  qvr_udiv u_div_z (.clk(clk), .in_dvd(dvd_z), .in_dsr(dsr), .out_quo(quo_z));

  // side-band delay matching the divider depth
  logic [DivStg:1] dl_vld_r;
  qvr_in_t         dl_req_r  [1:DivStg];
  logic [DivStg:1] dl_zero_r;

  for (genvar g = 0; g < DivStg; g++) begin : g_dl
    logic    vld_cur;
    logic    zero_cur;
    qvr_in_t req_cur;
    if (g == 0) begin : g_head
      assign vld_cur  = sq_vld;
      assign req_cur  = sq_req;
      assign zero_cur = sq_zero;
    end else begin : g_body
      assign vld_cur  = dl_vld_r[g];
      assign req_cur  = dl_req_r[g];
      assign zero_cur = dl_zero_r[g];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_vld_r[g+1] <= 1'b0;
      end else begin
        dl_vld_r[g+1] <= vld_cur;
      end
      dl_req_r[g+1]  <= req_cur;
      dl_zero_r[g+1] <= zero_cur;
    end
  end

  qvr_in_t dv_req;
  assign dv_req = dl_req_r[DivStg];

  // stage U: signed unit vector, Q2.14 in 16 bits (|u| <= 2^14)
  logic               u_vld_r, u_zero_r;
  logic signed [15:0] ux_r, uy_r, uz_r;
  logic signed [15:0] uw_r, uqx_r, uqy_r, uqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_vld_r <= 1'b0;
    end else begin
      u_vld_r <= dl_vld_r[DivStg];
    end
    u_zero_r <= dl_zero_r[DivStg];
    ux_r  <= dv_req.vec_x[15] ? -16'(quo_x) : 16'(quo_x);
    uy_r  <= dv_req.vec_y[15] ? -16'(quo_y) : 16'(quo_y);
    uz_r  <= dv_req.vec_z[15] ? -16'(quo_z) : 16'(quo_z);
    uw_r  <= dv_req.quat_w;
    uqx_r <= dv_req.quat_x;
    uqy_r <= dv_req.quat_y;
    uqz_r <= dv_req.quat_z;
  end

  // inner product stage A: twelve 16x16 products registered
  logic               a_vld_r, a_zero_r;
  logic signed [31:0] a_p_r [12];
  logic signed [15:0] aw_r, ax_r, ay_r, az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= u_vld_r;
    end
    a_zero_r  <= u_zero_r;
    a_p_r[0]  <= ux_r * uqx_r;  a_p_r[1]  <= uy_r * uqy_r;  a_p_r[2]  <= uz_r * uqz_r;
    a_p_r[3]  <= ux_r * uw_r;   a_p_r[4]  <= uy_r * uqz_r;  a_p_r[5]  <= uz_r * uqy_r;
    a_p_r[6]  <= ux_r * uqz_r;  a_p_r[7]  <= uy_r * uw_r;   a_p_r[8]  <= uz_r * uqx_r;
    a_p_r[9]  <= ux_r * uqy_r;  a_p_r[10] <= uy_r * uqx_r;  a_p_r[11] <= uz_r * uw_r;
    aw_r <= uw_r; ax_r <= uqx_r; ay_r <= uqy_r; az_r <= uqz_r;
  end

  // inner product stage B: t components (fit in 34 bits)
  logic               b_vld_r, b_zero_r;
  logic signed [33:0] tw_r, tx_r, ty_r, tz_r;
  logic signed [15:0] bw_r, bx_r, by_r, bz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_zero_r <= a_zero_r;
    tw_r <= 34'(a_p_r[0]) + 34'(a_p_r[1]) + 34'(a_p_r[2]);
    tx_r <= 34'(a_p_r[3]) - 34'(a_p_r[4]) + 34'(a_p_r[5]);
    ty_r <= 34'(a_p_r[6]) + 34'(a_p_r[7]) - 34'(a_p_r[8]);
    tz_r <= 34'(a_p_r[10]) - 34'(a_p_r[9]) + 34'(a_p_r[11]);
    bw_r <= aw_r; bx_r <= ax_r; by_r <= ay_r; bz_r <= az_r;
  end

  // outer product stage C: twelve 16x34 products
  logic               c_vld_r, c_zero_r;
  logic signed [49:0] c_p_r [12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_zero_r <= b_zero_r;
    c_p_r[0]  <= bx_r * tw_r;  c_p_r[1]  <= by_r * tz_r;  c_p_r[2]  <= bz_r * ty_r;
    c_p_r[3]  <= bw_r * tx_r;  c_p_r[4]  <= bx_r * tz_r;  c_p_r[5]  <= by_r * tw_r;
    c_p_r[6]  <= bz_r * tx_r;  c_p_r[7]  <= bw_r * ty_r;  c_p_r[8]  <= bx_r * ty_r;
    c_p_r[9]  <= by_r * tx_r;  c_p_r[10] <= bz_r * tw_r;  c_p_r[11] <= bw_r * tz_r;
  end

  // outer product stage D: sums
  logic               d_vld_r, d_zero_r;
  logic signed [51:0] rx_r, ry_r, rz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_zero_r <= c_zero_r;
    rx_r <= 52'(c_p_r[0]) + 52'(c_p_r[1]) - 52'(c_p_r[2]) + 52'(c_p_r[3]);
    ry_r <= 52'(c_p_r[5]) - 52'(c_p_r[4]) + 52'(c_p_r[6]) + 52'(c_p_r[7]);
    rz_r <= 52'(c_p_r[8]) - 52'(c_p_r[9]) + 52'(c_p_r[10]) + 52'(c_p_r[11]);
  end

  // round half up to 14 fraction bits, then saturate
  function automatic logic signed [15:0] rnd_sat(logic signed [51:0] r);
    logic signed [51:0] a;
    logic signed [23:0] q;
    a = r + 52'sd134217728;
    q = a[51:28];
    if (q > 24'sd32767) return 16'sh7fff;
    if (q < -24'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= d_vld_r;
    end
    out_data.rot_x       <= d_zero_r ? 16'sd0 : rnd_sat(rx_r);
    out_data.rot_y       <= d_zero_r ? 16'sd0 : rnd_sat(ry_r);
    out_data.rot_z       <= d_zero_r ? 16'sd0 : rnd_sat(rz_r);
    out_data.zero_vector <= d_zero_r;
  end

endmodule
`default_nettype wire
